FILE: rtl/hirs_pkg.sv
// Shared types and constants for the HID idle-rate report scheduler.
// Depends on nothing; the controller, datapath and top-level files import it.
package hirs_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam logic [7:0] STEP_DOWN  = 8'd5;
    localparam logic [7:0] STEP_FLOOR = 8'd4;
    localparam logic [3:0] CFG_RESET  = 4'd1;

    typedef enum logic [1:0] {
        CMD_TICK60   = 2'd0,
        CMD_TICK22   = 2'd1,
        CMD_SET_IDLE = 2'd2,
        CMD_GET_IDLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_RATE   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic set_write;
        logic walk;
        logic idx_clr;
        logic idx_inc;
        logic push_send;
        logic push_get;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic none_active;
        logic last_idx;
        logic pending_any;
        logic pending_cur;
        logic higher_none;
        logic host_ready;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/hirs_if.sv
// Handshake channels of the HID idle-rate report scheduler: request and result.
// Depends on nothing; payload widths are fixed by the field definitions.
interface hirs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] changed_mask;
    logic [7:0] report_id;
    logic [7:0] idle_rate;
    logic       host_ready;

    modport source (output valid, command, changed_mask, report_id, idle_rate, host_ready,
                    input ready);
    modport sink   (input valid, command, changed_mask, report_id, idle_rate, host_ready,
                    output ready);
endinterface

interface hirs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [3:0] send_report_id;
    logic [7:0] reply_rate;
    logic       last;

    modport source (output valid, result_kind, send_report_id, reply_rate, last,
                    input ready);
    modport sink   (input valid, result_kind, send_report_id, reply_rate, last,
                    output ready);
endinterface

FILE: rtl/hirs_ctrl.sv
// Controller of the HID idle-rate report scheduler: sequences one request at a time.
// Depends on hirs_pkg for the command and status structs.
module hirs_ctrl
    import hirs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_GET,
        S_WALK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    case (i_status.cmd)
                        CMD_SET_IDLE: n_state = S_SET;
                        CMD_GET_IDLE: n_state = S_GET;
                        CMD_TICK22:   n_state = i_status.none_active ? S_IDLE : S_WALK;
                        default:      n_state = S_EMIT;
                    endcase
                end
            end
            S_SET: begin
                o_cmd.set_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_GET: begin
                if (i_status.out_free) begin
                    o_cmd.push_get = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.last_idx) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_EMIT: begin
                // A host that cannot take reports drops every pending one.
                if (!i_status.pending_any || !i_status.host_ready) begin
                    n_state = S_IDLE;
                end else if (i_status.pending_cur) begin
                    if (i_status.out_free) begin
                        o_cmd.push_send = 1'b1;
                        if (i_status.higher_none || i_status.last_idx) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                end else if (i_status.last_idx) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/hirs_dp.sv
// Datapath of the HID idle-rate report scheduler: rate and countdown tables,
// pending mask, walk index and the result register. Depends on hirs_pkg.
module hirs_dp
    import hirs_pkg::*;
#(
    parameter int REPORT_SLOTS = SLOTS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic [1:0] i_command,
    input  logic [7:0] i_changed_mask,
    input  logic [7:0] i_report_id,
    input  logic [7:0] i_idle_rate,
    input  logic       i_host_ready,
    input  logic       i_out_ready,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output logic [1:0] o_result_kind,
    output logic [3:0] o_send_report_id,
    output logic [7:0] o_reply_rate,
    output logic       o_last
);

    localparam int         IdxW  = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
    localparam logic [3:0] Slots = 4'(REPORT_SLOTS);

    logic [3:0]              r_reports_in_use;
    logic [7:0]              r_rate [REPORT_SLOTS];
    logic [7:0]              r_count [REPORT_SLOTS];
    logic [REPORT_SLOTS-1:0] r_pending;
    logic [IdxW-1:0]         r_idx;
    logic [7:0]              r_id;
    logic [7:0]              r_new_rate;
    logic                    r_host_ready;

    logic                    r_out_valid;
    t_kind                   r_kind;
    logic [3:0]              r_send_id;
    logic [7:0]              r_reply_rate;
    logic                    r_last;

    logic [3:0]              n_active;
    logic [REPORT_SLOTS-1:0] active_mask;
    logic [REPORT_SLOTS-1:0] higher_pending;
    logic [7:0]              cur_rate;
    logic [7:0]              cur_count;
    logic                    id_valid;
    logic                    out_free;

    assign n_active = (r_reports_in_use > Slots) ? Slots : r_reports_in_use;

    always_comb begin
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            active_mask[i]    = (4'(i) < n_active);
            higher_pending[i] = r_pending[i] && (4'(i) > 4'(r_idx));
        end
    end

    assign cur_rate  = r_rate[r_idx];
    assign cur_count = r_count[r_idx];
    assign id_valid  = (r_id != 8'd0) && (r_id <= 8'(REPORT_SLOTS));
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_status             = '0;
        o_status.cmd         = t_cmd'(i_command);
        o_status.none_active = (n_active == 4'd0);
        o_status.last_idx    = (4'(r_idx) == n_active - 4'd1);
        o_status.pending_any = |r_pending;
        o_status.pending_cur = r_pending[r_idx];
        o_status.higher_none = ~|higher_pending;
        o_status.host_ready  = r_host_ready;
        o_status.out_free    = out_free;
    end

    // Configuration and the two tables are reset here: tables to zero, reports in use to 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reports_in_use <= CFG_RESET;
            for (int i = 0; i < REPORT_SLOTS; i++) begin
                r_rate[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_reports_in_use <= i_cfg_wdata;
            end
            if (i_cmd.set_write) begin
                for (int i = 0; i < REPORT_SLOTS; i++) begin
                    if (r_id == 8'd0 || r_id == 8'(i + 1)) begin
                        r_rate[i] <= r_new_rate;
                    end
                end
            end
            if (i_cmd.walk && cur_rate != 8'd0) begin
                if (cur_count > STEP_FLOOR) begin
                    r_count[r_idx] <= cur_count - STEP_DOWN;
                end else begin
                    r_count[r_idx] <= cur_rate;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id         <= i_report_id;
            r_new_rate   <= i_idle_rate;
            r_host_ready <= i_host_ready;
            if (t_cmd'(i_command) == CMD_TICK60) begin
                r_pending <= i_changed_mask[REPORT_SLOTS-1:0] & active_mask;
            end else begin
                r_pending <= '0;
            end
            if (t_cmd'(i_command) == CMD_GET_IDLE) begin
                r_idx <= IdxW'(i_report_id - 8'd1);
            end else begin
                r_idx <= '0;
            end
        end else begin
            if (i_cmd.walk && cur_rate != 8'd0 && cur_count <= STEP_FLOOR) begin
                r_pending[r_idx] <= 1'b1;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IdxW'(1);
            end
        end
    end

    // Result register: a finished beat waits here while the controller moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_send || i_cmd.push_get) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_send) begin
            r_kind       <= KIND_SEND;
            r_send_id    <= 4'(r_idx) + 4'd1;
            r_reply_rate <= '0;
            r_last       <= ~|higher_pending;
        end else if (i_cmd.push_get) begin
            r_kind       <= id_valid ? KIND_RATE : KIND_REJECT;
            r_send_id    <= '0;
            r_reply_rate <= id_valid ? cur_rate : 8'd0;
            r_last       <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_send_report_id = r_send_id;
    assign o_reply_rate     = r_reply_rate;
    assign o_last           = r_last;

endmodule

FILE: rtl/hid_idle_rate_report_scheduler.sv
// Set idle writes the rate table in the state after acceptance; get idle waits for a free result
// register, then puts its reply there. A 60 Hz tick runs the emit pass, a 22 ms tick the walk pass
// and then the emit pass, or neither with no reports in use; each pass visits one table entry per
// cycle unless the emit pass stalls on a busy result register.
// One request is handled at a time; the next is taken once the previous has finished.
// Synchronous active-low reset clears both tables to zero and sets reports in use to 1.
module hid_idle_rate_report_scheduler
    import hirs_pkg::*;
#(
    parameter int REPORT_SLOTS = SLOTS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    hirs_in_if.sink    i_item,
    hirs_out_if.source o_result
);

    t_ctrl_cmd  s_cmd;
    t_dp_status s_status;
    logic       s_in_ready;
    logic       s_accept;

    assign i_item.ready = s_in_ready;
    assign s_accept     = i_item.valid && s_in_ready;

    hirs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_status   (s_status),
        .o_in_ready (s_in_ready),
        .o_cmd      (s_cmd)
    );

    hirs_dp #(
        .REPORT_SLOTS (REPORT_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_command        (i_item.command),
        .i_changed_mask   (i_item.changed_mask),
        .i_report_id      (i_item.report_id),
        .i_idle_rate      (i_item.idle_rate),
        .i_host_ready     (i_item.host_ready),
        .i_out_ready      (o_result.ready),
        .i_cmd            (s_cmd),
        .o_status         (s_status),
        .o_out_valid      (o_result.valid),
        .o_result_kind    (o_result.result_kind),
        .o_send_report_id (o_result.send_report_id),
        .o_reply_rate     (o_result.reply_rate),
        .o_last           (o_result.last)
    );

    // A new beat is only written when the result register is free.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.push_send || s_cmd.push_get) |-> s_status.out_free)
        else $error("result beat written over an untaken one");

    a_push_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.push_send, s_cmd.push_get}))
        else $error("two result beats in one cycle");

    // A 22 ms tick with no reports in use finishes in its accepting cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !(s_status.cmd == CMD_TICK22 && s_status.none_active)) |=> !s_in_ready)
        else $error("request accepted while the previous one is in progress");

    a_load_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load |-> s_accept)
        else $error("request registers loaded without an accepted beat");

endmodule
